[rtl/msi_pkg.sv]
// Shared types and constants for the merge insertion sorter.
package msi_pkg;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;

  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_DUP  = 2'd1;
  localparam status_t STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_ERR
  } state_t;

  // per-cycle command to every cell of the row
  typedef struct packed {
    logic ins;    // insert the incoming value at its sorted place
    logic shift;  // move every entry one cell towards the head
    logic clr;    // empty the whole row
  } cell_ctrl_t;

endpackage

[rtl/msi_if.sv]
// Input and output stream interfaces of the merge insertion sorter.
interface msi_in_if import msi_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface msi_out_if import msi_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  value_out;
  status_t status;
  logic    last_out;

  modport source (output valid, output value_out, output status, output last_out, input ready);
  modport sink (input valid, input value_out, input status, input last_out, output ready);
endinterface

[rtl/msi_cell.sv]
// One cell of the sorted insertion row: holds one entry and passes it to a neighbour.
module msi_cell import msi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  value_t     v,
  input  logic       prev_take,
  input  value_t     prev_value,
  input  logic       prev_valid,
  input  value_t     next_value,
  input  logic       next_valid,
  output value_t     value,
  output logic       valid,
  output logic       take,
  output logic       eq
);

  value_t value_next;
  logic   valid_next;

  // empty cells count as holding infinity, so take is monotonic along the row
  assign take = !valid || (v < value);
  assign eq   = valid && (v == value);

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.clr) begin
      valid_next = 1'b0;
    end else if (ctrl.shift) begin
      value_next = next_value;
      valid_next = next_valid;
    end else if (ctrl.ins && take) begin
      if (prev_take) begin
        value_next = prev_value;
        valid_next = prev_valid;
      end else begin
        value_next = v;
        valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/merge_insertion_sorter.sv]
// Top level of the merge insertion sorter: cell row, control and output register.
//
//  channel  dir  fields                          accepted when
//  in_ch    in   value[30:0], last               valid && ready
//  out_ch   out  value_out[30:0], status, last_out valid && ready
//
// Each value is inserted in the cycle it is accepted, unless its set has hit an error:
// one item per cycle while collecting. After the last item of a set, the row drains
// one result per cycle from its head cell, so a set of N values gives N results,
// or one error result; input stays stalled until the drain is done.
// Synchronous reset empties the row. Output stalls hold the drain in place.
module merge_insertion_sorter import msi_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst,
  msi_in_if.sink    in_ch,
  msi_out_if.source out_ch
);

  state_t     state, state_next;
  status_t    err, err_next;
  cell_ctrl_t ctrl;

  value_t cell_value [MAX_ITEMS];
  logic   cell_valid [MAX_ITEMS];
  logic   cell_take  [MAX_ITEMS];
  logic   [MAX_ITEMS-1:0] cell_eq;

  logic    accept, dup, full, load_out;
  status_t err_after;

  value_t  value_out;
  status_t status;
  logic    last_out;
  logic    out_valid;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      value_t pv, nv;
      logic   pt, pvld, nvld;
      if (gi == 0) begin : g_head
        assign pt   = 1'b0;
        assign pv   = '0;
        assign pvld = 1'b0;
      end else begin : g_body
        assign pt   = cell_take[gi-1];
        assign pv   = cell_value[gi-1];
        assign pvld = cell_valid[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_tail
        assign nv   = '0;
        assign nvld = 1'b0;
      end else begin : g_inner
        assign nv   = cell_value[gi+1];
        assign nvld = cell_valid[gi+1];
      end
      msi_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .v          (in_ch.value),
        .prev_take  (pt),
        .prev_value (pv),
        .prev_valid (pvld),
        .next_value (nv),
        .next_valid (nvld),
        .value      (cell_value[gi]),
        .valid      (cell_valid[gi]),
        .take       (cell_take[gi]),
        .eq         (cell_eq[gi])
      );
    end
  endgenerate

  assign accept = in_ch.valid && in_ch.ready;
  assign dup    = |cell_eq;
  assign full   = cell_valid[MAX_ITEMS-1];

  // first error of a set wins
  always_comb begin
    priority if (err != STATUS_OK) begin
      err_after = err;
    end else if (dup) begin
      err_after = STATUS_DUP;
    end else if (full) begin
      err_after = STATUS_FULL;
    end else begin
      err_after = STATUS_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (accept && in_ch.last) begin
          state_next = (err_after != STATUS_OK) ? ST_ERR : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out && !cell_valid[1]) begin
          state_next = ST_COLLECT;
        end
      end
      ST_ERR: begin
        if (load_out) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.clr    = 1'b0;
    err_next    = err;
    unique case (state)
      ST_COLLECT: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          ctrl.ins = (err_after == STATUS_OK);
          err_next = err_after;
        end
      end
      ST_DRAIN: begin
        load_out   = !out_valid || out_ch.ready;
        ctrl.shift = load_out;
      end
      ST_ERR: begin
        load_out = !out_valid || out_ch.ready;
        // the values of a failed set are dropped with the error item
        ctrl.clr = load_out;
        if (load_out) begin
          err_next = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      err       <= STATUS_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      err   <= err_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == ST_ERR) begin
        value_out <= '0;
        status    <= err;
        last_out  <= 1'b1;
      end else begin
        value_out <= cell_value[0];
        status    <= STATUS_OK;
        last_out  <= !cell_valid[1];
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.value_out = value_out;
  assign out_ch.status    = status;
  assign out_ch.last_out  = last_out;

endmodule

[rtl/msi_checker.sv]
// Port-level checks for the merge insertion sorter, bound to the top level.
module msi_checker import msi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input logic    req_last,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input value_t  rsp_value,
  input status_t rsp_status,
  input logic    rsp_last
);

  // a result waiting for the sink must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
      && $stable(rsp_status) && $stable(rsp_last))
    else $error("output item changed while stalled");

  // an error result is a lone zero item that closes the set
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_value == '0)
    else $error("malformed error item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_DUP
      || rsp_status == STATUS_FULL)
    else $error("unknown status code");

  // once a set closes, input stays stalled while its results go out
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_last |=> !req_ready)
    else $error("input taken right after end of set");

endmodule

bind merge_insertion_sorter msi_checker u_msi_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (in_ch.valid),
  .req_ready  (in_ch.ready),
  .req_last   (in_ch.last),
  .rsp_valid  (out_ch.valid),
  .rsp_ready  (out_ch.ready),
  .rsp_value  (out_ch.value_out),
  .rsp_status (out_ch.status),
  .rsp_last   (out_ch.last_out)
);

[verif/tb_merge_insertion_sorter.sv]
// Self-checking testbench for the merge insertion sorter: directed table, random sets, overflow.
`timescale 1ns / 1ps

module tb_merge_insertion_sorter;
  import msi_pkg::*;

  localparam int MAX_ITEMS    = 64;
  localparam int RANDOM_ITEMS = 16;
  localparam int PRESSURE_SET = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 2 * MAX_ITEMS + 20;
  localparam value_t VALUE_MAX = '1;

  typedef struct packed {
    value_t  value;
    status_t status;
    logic    last;
  } sorted_item_t;

  typedef struct packed {
    value_t  value;
    logic    last;
    logic    typed;
    value_t  want_value;
    status_t want_status;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  // typed rows are single-result sets: the final item always carries last_out
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{31'd0,          1'b1, 1'b1, 31'd0,     STATUS_OK},   // smallest value alone
    '{VALUE_MAX,      1'b1, 1'b1, VALUE_MAX, STATUS_OK},   // largest value alone
    '{31'd5,          1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd3,          1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd5,          1'b0, 1'b0, 31'd0,     STATUS_OK},   // repeat mid-set
    '{31'd7,          1'b1, 1'b1, 31'd0,     STATUS_DUP},  // ignored after the error
    '{31'd9,          1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd9,          1'b1, 1'b1, 31'd0,     STATUS_DUP},  // repeat on the final item
    '{VALUE_MAX,      1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd0,          1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'h2AAAAAAA,   1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'h55555555,   1'b1, 1'b0, 31'd0,     STATUS_OK},
    '{31'd40,         1'b0, 1'b0, 31'd0,     STATUS_OK},   // descending input
    '{31'd30,         1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd20,         1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd10,         1'b1, 1'b0, 31'd0,     STATUS_OK},
    '{31'd1,          1'b0, 1'b0, 31'd0,     STATUS_OK},   // already ascending
    '{31'd2,          1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd3,          1'b1, 1'b0, 31'd0,     STATUS_OK},
    '{31'd100,        1'b0, 1'b0, 31'd0,     STATUS_OK},
    '{31'd100,        1'b0, 1'b0, 31'd0,     STATUS_OK},   // first error is kept
    '{31'd100,        1'b1, 1'b1, 31'd0,     STATUS_DUP}
  };

  logic clk;
  logic rst;

  msi_in_if  in_ch ();
  msi_out_if out_ch ();

  merge_insertion_sorter #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // sorter model state
  value_t  held_vals[$];
  status_t held_err = STATUS_OK;

  sorted_item_t sorted_expect_q[$];

  int  fail_count      = 0;
  int  items_fed       = 0;
  int  sets_closed     = 0;
  int  error_sets      = 0;
  int  results_checked = 0;
  int  idle_cycles     = 0;
  int  burst_left      = 0;
  bit  offer_open      = 0;
  bit  hold_req        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // absorb one value; on the final item of a set, produce its results
  function automatic void predict_sorted_set(value_t v, logic l, output sorted_item_t res[$]);
    int pos;
    res = {};
    pos = 0;
    if (held_err == STATUS_OK) begin
      while (pos < held_vals.size() && held_vals[pos] < v) pos++;
      if (pos < held_vals.size() && held_vals[pos] == v) held_err = STATUS_DUP;
      else if (held_vals.size() >= MAX_ITEMS) held_err = STATUS_FULL;
      else held_vals.insert(pos, v);
    end
    if (l) begin
      sets_closed++;
      if (held_err != STATUS_OK) begin
        error_sets++;
        res.insert(res.size(), sorted_item_t'{'0, held_err, 1'b1});
      end else begin
        foreach (held_vals[k])
          res.insert(res.size(),
                     sorted_item_t'{held_vals[k], STATUS_OK, k == held_vals.size() - 1});
      end
      held_vals = {};
      held_err  = STATUS_OK;
    end
  endfunction

  task automatic feed(value_t v, logic l, logic typed, value_t wv, status_t ws);
    sorted_item_t res[$];
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    offer_open = 1;
    do @(posedge clk); while (!in_ch.ready);
    items_fed++;
    predict_sorted_set(v, l, res);
    if (typed) sorted_expect_q.insert(sorted_expect_q.size(), sorted_item_t'{wv, ws, 1'b1});
    else foreach (res[k]) sorted_expect_q.insert(sorted_expect_q.size(), res[k]);
    // burst pacing: gaps land between random runs of back-to-back items
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        offer_open = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic feed_set(input value_t vals[$]);
    foreach (vals[i]) feed(vals[i], i == vals.size() - 1, 1'b0, '0, STATUS_OK);
  endtask

  function automatic value_t draw_value();
    case ($urandom_range(0, 3))
      0: return value_t'($urandom_range(0, 15));
      1: return VALUE_MAX - value_t'($urandom_range(0, 15));
      default: return value_t'($urandom());
    endcase
  endfunction

  function automatic void distinct_values(int n, bit wide, output value_t vals[$]);
    value_t v;
    bit clash;
    vals = {};
    while (vals.size() < n) begin
      v = wide ? value_t'($urandom()) : draw_value();
      clash = 0;
      foreach (vals[i]) if (vals[i] == v) clash = 1;
      if (!clash) vals.insert(vals.size(), v);
    end
  endfunction

  // stimulus
  initial begin
    value_t vals[$];
    int n;
    int kind;
    int p;
    int random_items;
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i])
      feed(DIR_TAB[i].value, DIR_TAB[i].last, DIR_TAB[i].typed,
           DIR_TAB[i].want_value, DIR_TAB[i].want_status);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      if (kind < 6) begin
        distinct_values(n, 1'b0, vals);
      end else if (kind < 8) begin
        if (n < 2) n = 2;
        distinct_values(n, 1'b0, vals);
        p = $urandom_range(1, n - 1);
        vals[p] = vals[$urandom_range(0, p - 1)];
      end else begin
        // narrow pool: repeats happen on their own
        vals = {};
        repeat (n) vals.insert(vals.size(), value_t'($urandom_range(0, 7)));
      end
      feed_set(vals);
      random_items += n;
    end

    // long output hold: a set goes in and the next one queues up behind its drain
    hold_req = 1;
    distinct_values(PRESSURE_SET, 1'b1, vals);
    feed_set(vals);
    // overflow, then a repeat on the final item: the full error must win
    distinct_values(MAX_ITEMS + 2, 1'b1, vals);
    vals[MAX_ITEMS + 1] = vals[5];
    feed_set(vals);

    if (offer_open) in_ch.valid <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items in %0d sets (%0d with an error), %0d results checked;",
             items_fed, sets_closed, error_sets, results_checked);
    $display("including a store overflow and a %0d-cycle output hold.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS merge_insertion_sorter");
    end else begin
      $display("FAIL merge_insertion_sorter");
    end
    $finish;
  end

  // result side: stall segments of random density, plus one long hold
  initial begin
    int seg_left;
    int pct;
    int held;
    out_ch.ready <= 1'b0;
    seg_left = 0;
    pct      = 100;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 75;
          2: pct = 50;
          default: pct = 20;
        endcase
      end
      seg_left--;
      out_ch.ready <= ($urandom_range(1, 100) <= pct);
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    sorted_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (sorted_expect_q.size() == 0) begin
        $error("unexpected result: value_out=%0d status=%0d last_out=%0b",
               out_ch.value_out, out_ch.status, out_ch.last_out);
        fail_count++;
      end else begin
        want = sorted_expect_q[0];
        sorted_expect_q.delete(0);
        results_checked++;
        if (out_ch.value_out !== want.value) begin
          $error("value_out: expected %0d, got %0d", want.value, out_ch.value_out);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.last_out !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, out_ch.last_out);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("timeout: no handshake for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sorted_expect_q.size());
      $display("FAIL merge_insertion_sorter");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
rtl/msi_pkg.sv
rtl/msi_if.sv
rtl/msi_cell.sv
rtl/merge_insertion_sorter.sv
rtl/msi_checker.sv
verif/tb_merge_insertion_sorter.sv
